// ----- rtl/pdr_pkg.sv -----
// pdr_pkg: shared types, register indexes, constants and the quarter-wave
// sine table for the plasma dissolve pixel reveal block.
// No dependencies.
`timescale 1ns / 1ps

package pdr_pkg;

    localparam int MAX_SCALE        = 8;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int CHROMA_KEY       = 0;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QW      = IDX_W - 2;
    localparam int CNT_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SCALE_W = 4;
    localparam int DX_W    = 13;
    localparam int CL_W    = DX_W + 1;

    localparam logic [31:0] SEED_MUL   = 32'd2654435761;
    localparam logic [15:0] PH_MUL_X   = 16'd3338;
    localparam logic [15:0] PH_MUL_Y   = 16'd2921;
    localparam logic [15:0] PH_MUL_XY  = 16'd2295;
    localparam logic signed [19:0] PLASMA_BIAS = 20'sd98304;
    localparam logic [11:0] SCREEN_MAX = 12'd2048;

    localparam logic [2:0] REG_SEED          = 3'd0;
    localparam logic [2:0] REG_THRESHOLD     = 3'd1;
    localparam logic [2:0] REG_REVEAL_MODE   = 3'd2;
    localparam logic [2:0] REG_BLOCK_SCALE   = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd5;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

    localparam logic [1:0] REVEAL_NONE     = 2'd0;
    localparam logic [1:0] REVEAL_DISSOLVE = 2'd1;
    localparam logic [1:0] REVEAL_ALL      = 2'd2;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef logic [14:0] qsin_tab_t [QUARTER];

    typedef struct packed {
        logic [7:0]         p1;
        logic [7:0]         p2;
        logic [7:0]         p3;
        logic [16:0]        threshold;
        logic [1:0]         mode;
        logic [SCALE_W-1:0] scale;
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [11:0]        width;
        logic [11:0]        height;
    } pdr_cfg_t;

    typedef struct packed {
        logic [7:0] src_x;
        logic [7:0] src_y;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pdr_pix_t;

    typedef struct packed {
        logic signed [DX_W-1:0] dx0;
        logic signed [DX_W-1:0] dy0;
        logic [CNT_W-1:0]       bx_lo;
        logic [CNT_W-1:0]       bx_hi;
        logic [CNT_W-1:0]       by_lo;
        logic [CNT_W-1:0]       by_hi;
        logic [7:0]             blue;
        logic [7:0]             green;
        logic [7:0]             red;
    } pdr_blk_t;

    // Taylor sine, degree 11, Horner in Q30 with truncating steps
    function automatic longint quarter_sine(longint x);
        longint x2;
        longint t;
        longint s;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        return (s * 32767 + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic qsin_tab_t build_qsin();
        qsin_tab_t tab;
        longint    x;
        for (int m = 0; m < QUARTER; m++)
        begin
            x = (longint'(4 * m) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            tab[m] = 15'(quarter_sine(x));
        end
        return tab;
    endfunction

    localparam qsin_tab_t   QSIN     = build_qsin();
    localparam logic [14:0] QSIN_TOP = 15'(quarter_sine(HALF_PI_Q30));

    function automatic logic signed [15:0] sine_lookup(logic [IDX_W-1:0] idx);
        logic [1:0]    quad;
        logic [QW-1:0] m;
        logic [QW:0]   mm;
        logic [14:0]   mag;
        quad = idx[IDX_W-1 -: 2];
        m    = idx[QW-1:0];
        mm   = (QW+1)'(QUARTER) - {1'b0, m};
        if (quad[0] && (m == '0))
            mag = QSIN_TOP;
        else if (quad[0])
            mag = QSIN[mm[QW-1:0]];
        else
            mag = QSIN[m];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ----- rtl/pdr_plasma_pipe.sv -----
// pdr_plasma_pipe: four-stage pipeline: phases, sine lookup, threshold test
// and block origin, clip ranges. Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_plasma_pipe
    import pdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pdr_cfg_t cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  pdr_pix_t in_pix,
    output logic     out_valid,
    input  logic     out_ready,
    output pdr_blk_t out_blk
);

    logic rdy1, rdy2, rdy3, rdy4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: phases
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic             all1_reg;
    logic [7:0]       col1_reg, row1_reg;
    logic [23:0]      rgb1_reg;

    // stage 2: sines
    logic signed [15:0] sin1_reg, sin2_reg, sin3_reg;
    logic               all2_reg;
    logic [7:0]         col2_reg, row2_reg;
    logic [23:0]        rgb2_reg;

    // stage 3: block origin
    logic signed [DX_W-1:0] dx0_reg, dy0_reg;
    logic [23:0]            rgb3_reg;

    pdr_blk_t blk4_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    logic [15:0] ph1, ph2, ph3;
    logic [8:0]  sxy;
    logic        key_hit, mode_on;

    assign sxy     = {1'b0, in_pix.src_x} + {1'b0, in_pix.src_y};
    assign ph1     = ({8'b0, in_pix.src_x} * PH_MUL_X) + {cfg.p1, 8'h00};
    assign ph2     = ({8'b0, in_pix.src_y} * PH_MUL_Y) + {cfg.p2, 8'h00};
    assign ph3     = ({7'b0, sxy} * PH_MUL_XY) + {cfg.p3, 8'h00};
    assign key_hit = ({in_pix.red, in_pix.green, in_pix.blue} == 24'(CHROMA_KEY));
    assign mode_on = (cfg.mode == REVEAL_ALL) || (cfg.mode == REVEAL_DISSOLVE);

    // stage 3 logic
    logic signed [17:0] sin_sum;
    logic signed [19:0] lhs, rhs;
    logic [18:0]        thr3;
    logic               show;
    logic [11:0]        col_mul, row_mul;
    logic signed [DX_W-1:0] dx0_w, dy0_w;

    assign sin_sum = 18'(sin1_reg) + 18'(sin2_reg) + 18'(sin3_reg);
    assign lhs     = 20'(sin_sum) + PLASMA_BIAS;
    assign thr3    = {1'b0, cfg.threshold, 1'b0} + {2'b0, cfg.threshold};
    assign rhs     = $signed({1'b0, thr3});
    assign show    = all2_reg || (lhs <= rhs);
    assign col_mul = {4'b0, col2_reg} * {8'b0, cfg.scale};
    assign row_mul = {4'b0, row2_reg} * {8'b0, cfg.scale};
    assign dx0_w   = {{(DX_W-11){cfg.origin_x[10]}}, cfg.origin_x}
                     + $signed({1'b0, col_mul});
    assign dy0_w   = {{(DX_W-11){cfg.origin_y[10]}}, cfg.origin_y}
                     + $signed({1'b0, row_mul});

    // stage 4 logic: visible block rectangle
    logic signed [CL_W-1:0] ex, ey, smax, lo_x, lo_y, hi_x, hi_y, lim_x, lim_y;
    logic                   ne_x, ne_y;

    assign ex    = CL_W'(dx0_reg);
    assign ey    = CL_W'(dy0_reg);
    assign smax  = $signed(CL_W'({1'b0, cfg.scale})) - CL_W'(1);
    assign lim_x = $signed(CL_W'({1'b0, cfg.width})) - CL_W'(1) - ex;
    assign lim_y = $signed(CL_W'({1'b0, cfg.height})) - CL_W'(1) - ey;
    assign lo_x  = (ex < 0) ? -ex : '0;
    assign lo_y  = (ey < 0) ? -ey : '0;
    assign hi_x  = (lim_x < smax) ? lim_x : smax;
    assign hi_y  = (lim_y < smax) ? lim_y : smax;
    assign ne_x  = (lo_x <= hi_x);
    assign ne_y  = (lo_y <= hi_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid && !key_hit && mode_on;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg && show;
            if (rdy4)
                v4_reg <= v3_reg && ne_x && ne_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            idx1_reg <= ph1[15 -: IDX_W];
            idx2_reg <= ph2[15 -: IDX_W];
            idx3_reg <= ph3[15 -: IDX_W];
            all1_reg <= (cfg.mode == REVEAL_ALL);
            col1_reg <= in_pix.col;
            row1_reg <= in_pix.row;
            rgb1_reg <= {in_pix.red, in_pix.green, in_pix.blue};
        end
        if (rdy2)
        begin
            sin1_reg <= sine_lookup(idx1_reg);
            sin2_reg <= sine_lookup(idx2_reg);
            sin3_reg <= sine_lookup(idx3_reg);
            all2_reg <= all1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            rgb2_reg <= rgb1_reg;
        end
        if (rdy3)
        begin
            dx0_reg  <= dx0_w;
            dy0_reg  <= dy0_w;
            rgb3_reg <= rgb2_reg;
        end
        if (rdy4)
        begin
            blk4_reg.dx0   <= dx0_reg;
            blk4_reg.dy0   <= dy0_reg;
            blk4_reg.bx_lo <= lo_x[CNT_W-1:0];
            blk4_reg.bx_hi <= hi_x[CNT_W-1:0];
            blk4_reg.by_lo <= lo_y[CNT_W-1:0];
            blk4_reg.by_hi <= hi_y[CNT_W-1:0];
            blk4_reg.red   <= rgb3_reg[23:16];
            blk4_reg.green <= rgb3_reg[15:8];
            blk4_reg.blue  <= rgb3_reg[7:0];
        end
    end

    assign out_valid = v4_reg;
    assign out_blk   = blk4_reg;

endmodule

// ----- rtl/pdr_block_writer.sv -----
// pdr_block_writer: walks the visible part of one block, one screen write
// per cycle unless stalled, into an output register. Depends on pdr_pkg.
`timescale 1ns / 1ps

module pdr_block_writer
    import pdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pdr_blk_t    in_blk,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_data,
    output logic        m_last
);

    pdr_blk_t         blk_reg;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] bx_reg, by_reg;
    logic             mv_reg;
    logic [10:0]      dest_x_reg, dest_y_reg;
    logic [23:0]      rgb_reg;
    logic             last_reg;

    logic             emit, emit_last, take;
    logic [DX_W-1:0]  dx_w, dy_w;

    assign emit      = busy_reg && (!mv_reg || m_ready);
    assign emit_last = (bx_reg == blk_reg.bx_hi) && (by_reg == blk_reg.by_hi);
    assign in_ready  = !busy_reg || (emit && emit_last);
    assign take      = in_valid && in_ready;
    assign dx_w      = blk_reg.dx0 + DX_W'(bx_reg);
    assign dy_w      = blk_reg.dy0 + DX_W'(by_reg);

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
            busy_next = 1'b1;
        else if (emit && emit_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (emit)
                mv_reg <= 1'b1;
            else if (m_ready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_reg <= in_blk;
            bx_reg  <= in_blk.bx_lo;
            by_reg  <= in_blk.by_lo;
        end
        else if (emit)
        begin
            if (bx_reg == blk_reg.bx_hi)
            begin
                bx_reg <= blk_reg.bx_lo;
                by_reg <= by_reg + 1'b1;
            end
            else
            begin
                bx_reg <= bx_reg + 1'b1;
            end
        end
        if (emit)
        begin
            dest_x_reg <= dx_w[10:0];
            dest_y_reg <= dy_w[10:0];
            rgb_reg    <= {blk_reg.red, blk_reg.green, blk_reg.blue};
            last_reg   <= emit_last;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = {2'b00, rgb_reg, dest_y_reg, dest_x_reg};
    assign m_last  = last_reg;

endmodule

// ----- rtl/plasma_dissolve_pixel_reveal_top.sv -----
// Plasma dissolve pixel reveal: top level with configuration registers.
// Depends on pdr_pkg, pdr_plasma_pipe and pdr_block_writer.
//
// s_* carries one source logo pixel per request; m_* carries screen writes.
// The cfg_* port writes one register per cycle while cfg_wr_en is high;
// write only while no pixel is in flight.
// A pixel matching the chroma key, or failing the reveal test, makes no
// write. A shown pixel makes one write per visible screen position of its
// block_scale x block_scale block, rows top to bottom, left to right;
// m_tlast marks the final write of the pixel.
// The first write of a pixel passes through the four pipeline stages,
// the block walker and the output register. Throughput: one write per
// cycle while m_tready is high; the block walker takes the next block as
// it issues the last write of the current one. Reset clears the pipeline
// and loads register defaults (scale 1, screen 720 x 720). When m_tready
// is low the output holds and the pipeline fills, then s_tready drops;
// nothing is lost or repeated.
`timescale 1ns / 1ps

module plasma_dissolve_pixel_reveal_top
    import pdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // src_x, src_y, block_col, block_row, in_blue, in_green, in_red
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dest_x[10:0], dest_y[10:0], out_blue, out_green, out_red, zero fill
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    logic [23:0]        hash_reg;
    logic [16:0]        threshold_reg;
    logic [1:0]         mode_reg;
    logic [3:0]         scale_reg;
    logic signed [10:0] origin_x_reg, origin_y_reg;
    logic [11:0]        width_reg, height_reg;
    logic [31:0]        seed_hash;

    assign seed_hash = cfg_wr_data * SEED_MUL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            threshold_reg <= '0;
            mode_reg      <= REVEAL_NONE;
            scale_reg     <= 4'd1;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            width_reg     <= 12'd720;
            height_reg    <= 12'd720;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SEED:          hash_reg      <= seed_hash[23:0];
                REG_THRESHOLD:     threshold_reg <= cfg_wr_data[16:0];
                REG_REVEAL_MODE:   mode_reg      <= cfg_wr_data[1:0];
                REG_BLOCK_SCALE:   scale_reg     <= cfg_wr_data[3:0];
                REG_ORIGIN_X:      origin_x_reg  <= cfg_wr_data[10:0];
                REG_ORIGIN_Y:      origin_y_reg  <= cfg_wr_data[10:0];
                REG_SCREEN_WIDTH:  width_reg     <= cfg_wr_data[11:0];
                REG_SCREEN_HEIGHT: height_reg    <= cfg_wr_data[11:0];
                default:           ;
            endcase
        end
    end

    pdr_cfg_t cfg;

    always_comb
    begin
        cfg.p1        = hash_reg[7:0];
        cfg.p2        = hash_reg[15:8];
        cfg.p3        = hash_reg[23:16];
        cfg.threshold = threshold_reg;
        cfg.mode      = mode_reg;
        if (scale_reg == 4'd0)
            cfg.scale = 4'd1;
        else if (scale_reg > 4'(MAX_SCALE))
            cfg.scale = 4'(MAX_SCALE);
        else
            cfg.scale = scale_reg;
        cfg.origin_x  = origin_x_reg;
        cfg.origin_y  = origin_y_reg;
        cfg.width     = (width_reg > SCREEN_MAX) ? SCREEN_MAX : width_reg;
        cfg.height    = (height_reg > SCREEN_MAX) ? SCREEN_MAX : height_reg;
    end

    pdr_pix_t pix;

    assign pix.src_x = s_tdata[7:0];
    assign pix.src_y = s_tdata[15:8];
    assign pix.col   = s_tdata[23:16];
    assign pix.row   = s_tdata[31:24];
    assign pix.blue  = s_tdata[39:32];
    assign pix.green = s_tdata[47:40];
    assign pix.red   = s_tdata[55:48];

    logic     blk_valid, blk_ready;
    pdr_blk_t blk;

    pdr_plasma_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pix),
        .out_valid (blk_valid),
        .out_ready (blk_ready),
        .out_blk   (blk)
    );

    pdr_block_writer u_writer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (blk_valid),
        .in_ready (blk_ready),
        .in_blk   (blk),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

// ----- rtl/pdr_checker.sv -----
// pdr_checker: port-level assertions for the top level, attached by bind.
// Depends on plasma_dissolve_pixel_reveal_top.
`timescale 1ns / 1ps

module pdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // stalled write holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled write changed");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("write during reset");

    // writes of one block come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside block");

    // inside a block the row stays or steps down by one
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            (m_tdata[21:11] == $past(m_tdata[21:11])) ||
            (m_tdata[21:11] == $past(m_tdata[21:11]) + 11'd1))
        else $error("row jump inside block");

endmodule

bind plasma_dissolve_pixel_reveal_top pdr_checker u_pdr_checker (.*);

// ----- tb/sv/plasma_dissolve_pixel_reveal_top_tb.sv -----
// Self-checking testbench for plasma_dissolve_pixel_reveal_top: drives logo pixel
// requests, predicts the screen writes and compares them as they come out.
// Depends on pdr_pkg and the plasma_dissolve_pixel_reveal_top RTL.
`timescale 1ns / 1ps

module plasma_dissolve_pixel_reveal_top_tb;
    import pdr_pkg::*;

    localparam logic [1:0] REVEAL_UNUSED = 2'd3;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic        last;
        logic [1:0]  pad;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [10:0] dy;
        logic [10:0] dx;
    } scr_write_t;

    typedef struct {
        logic [31:0]        seed;
        logic [16:0]        thr;
        logic [1:0]         mode;
        logic [3:0]         scale;
        logic signed [10:0] ox;
        logic signed [10:0] oy;
        logic [11:0]        sw;
        logic [11:0]        sh;
    } dissolve_regs_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    dissolve_regs_t regs;
    int             sine_q15 [SINE_TABLE_DEPTH];
    scr_write_t     expected_writes [$];
    int             fail_count;
    int             bad_writes;
    bit             steady_flow;

    plasma_dissolve_pixel_reveal_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int taylor_sin_q15(longint ang);
        longint sq;
        longint acc;
        longint prod;
        longint divs [5];
        divs = '{110, 72, 42, 20, 6};
        sq   = (ang * ang) >>> 30;
        acc  = Q30_ONE;
        for (int k = 0; k < 5; k++)
            acc = Q30_ONE - ((sq * acc) >>> 30) / divs[k];
        prod = (ang * acc) >>> 30;
        return int'((prod * 32767 + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic void build_sine_table();
        longint quad;
        longint rem;
        longint r;
        int     mag;
        for (int j = 0; j < SINE_TABLE_DEPTH; j++)
        begin
            quad = (longint'(j) * 4) / SINE_TABLE_DEPTH;
            rem  = (longint'(j) * 4) % SINE_TABLE_DEPTH;
            r    = quad[0] ? SINE_TABLE_DEPTH - rem : rem;
            mag  = taylor_sin_q15(r * HALF_PI_Q30 / SINE_TABLE_DEPTH);
            sine_q15[j] = (quad >= 2) ? -mag : mag;
        end
    endfunction

    function automatic int sine_at(logic [15:0] ph);
        return sine_q15[int'((longint'(ph) * SINE_TABLE_DEPTH) >>> 16)];
    endfunction

    function automatic bit pixel_shown(pdr_pix_t p);
        logic [31:0] h;
        logic [15:0] ph1;
        logic [15:0] ph2;
        logic [15:0] ph3;
        int          v;
        if ({p.red, p.green, p.blue} == 24'(CHROMA_KEY))
            return 1'b0;
        if (regs.mode == REVEAL_ALL)
            return 1'b1;
        if (regs.mode != REVEAL_DISSOLVE)
            return 1'b0;
        h   = regs.seed * SEED_MUL;
        ph1 = {8'h00, p.src_x} * PH_MUL_X + {h[7:0], 8'h00};
        ph2 = {8'h00, p.src_y} * PH_MUL_Y + {h[15:8], 8'h00};
        ph3 = ({8'h00, p.src_x} + {8'h00, p.src_y}) * PH_MUL_XY + {h[23:16], 8'h00};
        v   = sine_at(ph1) + sine_at(ph2) + sine_at(ph3);
        return (v + 98304) <= 3 * int'(regs.thr);
    endfunction

    function automatic void predict_pixel_writes(pdr_pix_t p);
        scr_write_t blk [$];
        scr_write_t w;
        int         sc;
        int         sw;
        int         sh;
        int         x0;
        int         y0;
        if (!pixel_shown(p))
            return;
        sc = (regs.scale == 0) ? 1 :
             ((regs.scale > MAX_SCALE) ? MAX_SCALE : int'(regs.scale));
        sw = (regs.sw > 12'd2048) ? 2048 : int'(regs.sw);
        sh = (regs.sh > 12'd2048) ? 2048 : int'(regs.sh);
        x0 = int'(regs.ox) + int'(p.col) * sc;
        y0 = int'(regs.oy) + int'(p.row) * sc;
        for (int by = 0; by < sc; by++)
            for (int bx = 0; bx < sc; bx++)
                if (y0 + by >= 0 && y0 + by < sh && x0 + bx >= 0 && x0 + bx < sw)
                begin
                    w.last  = 1'b0;
                    w.pad   = 2'b00;
                    w.red   = p.red;
                    w.green = p.green;
                    w.blue  = p.blue;
                    w.dy    = 11'(y0 + by);
                    w.dx    = 11'(x0 + bx);
                    blk.push_back(w);
                end
        if (blk.size() > 0)
        begin
            w = blk[blk.size() - 1];
            w.last = 1'b1;
            blk[blk.size() - 1] = w;
        end
        foreach (blk[i])
            expected_writes.push_back(blk[i]);
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int idle_cycles();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pdr_pix_t pix(int sx, int sy, int col, int row, logic [23:0] rgb);
        pdr_pix_t p;
        p.src_x = 8'(sx);
        p.src_y = 8'(sy);
        p.col   = 8'(col);
        p.row   = 8'(row);
        p.red   = rgb[23:16];
        p.green = rgb[15:8];
        p.blue  = rgb[7:0];
        return p;
    endfunction

    function automatic pdr_pix_t random_pixel();
        logic [23:0] rgb;
        int          col;
        int          row;
        rgb = ($urandom_range(0, 9) == 0) ? 24'(CHROMA_KEY) : 24'($urandom);
        col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        return pix($urandom_range(0, 255), $urandom_range(0, 255), col, row, rgb);
    endfunction

    // entered and left at a falling edge; s_tvalid stays high for a back-to-back request
    task automatic send_pixel(pdr_pix_t p);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.red, p.green, p.blue, p.row, p.col, p.src_y, p.src_x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel_writes(p);
        @(negedge clk);
    endtask

    task automatic drain();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_writes.size() != 0)
        begin
            fail_count++;
            $display("ERROR: %0d expected writes never arrived", expected_writes.size());
            expected_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_SEED:          regs.seed  = val;
            REG_THRESHOLD:     regs.thr   = val[16:0];
            REG_REVEAL_MODE:   regs.mode  = val[1:0];
            REG_BLOCK_SCALE:   regs.scale = val[3:0];
            REG_ORIGIN_X:      regs.ox    = val[10:0];
            REG_ORIGIN_Y:      regs.oy    = val[10:0];
            REG_SCREEN_WIDTH:  regs.sw    = val[11:0];
            REG_SCREEN_HEIGHT: regs.sh    = val[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_regs(dissolve_regs_t r);
        set_reg(REG_SEED, r.seed);
        set_reg(REG_THRESHOLD, 32'(r.thr));
        set_reg(REG_REVEAL_MODE, 32'(r.mode));
        set_reg(REG_BLOCK_SCALE, 32'(r.scale));
        set_reg(REG_ORIGIN_X, 32'(r.ox));
        set_reg(REG_ORIGIN_Y, 32'(r.oy));
        set_reg(REG_SCREEN_WIDTH, 32'(r.sw));
        set_reg(REG_SCREEN_HEIGHT, 32'(r.sh));
    endtask

    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                hold = idle_cycles();
            end
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        scr_write_t got;
        scr_write_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata};
            if (expected_writes.size() == 0)
            begin
                fail_count++;
                bad_writes++;
                if (bad_writes <= MAX_REPORTS)
                    $display("ERROR: unexpected write x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                             got.dx, got.dy, got.red, got.green, got.blue, got.last);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    bad_writes++;
                    if (bad_writes <= MAX_REPORTS)
                        $display({"ERROR: write mismatch exp x=%0d y=%0d rgb=%02h%02h%02h ",
                                  "last=%0b pad=%0b, got x=%0d y=%0d rgb=%02h%02h%02h ",
                                  "last=%0b pad=%0b"},
                                 want.dx, want.dy, want.red, want.green, want.blue,
                                 want.last, want.pad, got.dx, got.dy, got.red,
                                 got.green, got.blue, got.last, got.pad);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // register defaults: nothing shown until a mode that shows is set; chroma key pixels stay hidden
    task automatic test_reset_defaults();
        drain();
        send_pixel(pix(12, 34, 1, 2, 24'hFFFFFF));
        send_pixel(pix(255, 0, 3, 4, 24'h804020));
        drain();
        set_reg(REG_REVEAL_MODE, 32'(REVEAL_UNUSED));
        send_pixel(pix(7, 9, 5, 5, 24'hFFFFFF));
        drain();
        set_reg(REG_REVEAL_MODE, 32'(REVEAL_ALL));
        send_pixel(pix(0, 0, 0, 0, 24'hFFFFFF));
        send_pixel(pix(255, 255, 255, 255, 24'h123456));
        send_pixel(pix(100, 100, 10, 10, 24'(CHROMA_KEY)));
        send_pixel(pix(1, 1, 20, 21, 24'(CHROMA_KEY) ^ 24'h000001));
        drain();
    endtask

    // large blocks at the screen edges, scale and screen size out of range
    task automatic test_block_clipping();
        set_reg(REG_BLOCK_SCALE, 32'd8);
        set_reg(REG_ORIGIN_X, -32'sd4);
        set_reg(REG_ORIGIN_Y, -32'sd4);
        set_reg(REG_SCREEN_WIDTH, 32'd2048);
        set_reg(REG_SCREEN_HEIGHT, 32'd2048);
        send_pixel(pix(3, 4, 0, 0, 24'hA5A5A5));
        send_pixel(pix(5, 6, 255, 255, 24'h5A5A5A));
        drain();
        set_reg(REG_ORIGIN_X, 32'd1023);
        set_reg(REG_ORIGIN_Y, 32'd1023);
        send_pixel(pix(0, 0, 0, 0, 24'hFF0000));
        send_pixel(pix(0, 0, 255, 0, 24'h00FF00));
        drain();
        set_reg(REG_ORIGIN_X, -32'sd1024);
        set_reg(REG_ORIGIN_Y, -32'sd1024);
        send_pixel(pix(9, 9, 0, 0, 24'h0000FF));
        send_pixel(pix(9, 9, 128, 128, 24'hFFFFFF));
        drain();
        set_reg(REG_ORIGIN_X, 32'd1023);
        set_reg(REG_ORIGIN_Y, 32'd1023);
        set_reg(REG_BLOCK_SCALE, 32'd15);
        send_pixel(pix(200, 17, 128, 128, 24'h010203));
        send_pixel(pix(17, 200, 127, 127, 24'hFEDCBA));
        drain();
        set_reg(REG_BLOCK_SCALE, 32'd0);
        set_reg(REG_SCREEN_WIDTH, 32'd0);
        send_pixel(pix(1, 2, 0, 0, 24'h777777));
        drain();
        set_reg(REG_SCREEN_WIDTH, 32'd4095);
        set_reg(REG_SCREEN_HEIGHT, 32'd4095);
        send_pixel(pix(2, 1, 255, 255, 24'h888888));
        drain();
    endtask

    // threshold dissolve at its extremes and with random seeds
    task automatic test_dissolve_sweep();
        dissolve_regs_t r;
        logic [16:0]    thr_list  [4];
        logic [31:0]    seed_list [4];
        thr_list  = '{17'd0, 17'd65536, 17'd32768, 17'($urandom_range(20000, 45000))};
        seed_list = '{32'hFFFFFFFF, 32'd0, $urandom, $urandom};
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            r.seed  = seed_list[ph];
            r.thr   = thr_list[ph];
            r.mode  = REVEAL_DISSOLVE;
            r.scale = 4'd1;
            r.ox    = 11'sd0;
            r.oy    = 11'sd0;
            r.sw    = 12'd720;
            r.sh    = 12'd720;
            apply_regs(r);
            repeat (12) send_pixel(random_pixel());
        end
        drain();
    endtask

    // random register settings, each followed by a run of random pixels
    task automatic test_random_frames();
        dissolve_regs_t r;
        int             pick;
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            steady_flow = ($urandom_range(0, 3) == 0);
            r.seed = $urandom;
            pick   = $urandom_range(0, 19);
            r.thr  = (pick < 2) ? 17'd0 : (pick < 4) ? 17'd65536 :
                     (pick < 5) ? 17'h1FFFF : 17'($urandom_range(0, 65536));
            pick   = $urandom_range(0, 19);
            r.mode = (pick < 10) ? REVEAL_DISSOLVE : (pick < 17) ? REVEAL_ALL :
                     (pick < 19) ? REVEAL_NONE : REVEAL_UNUSED;
            pick    = $urandom_range(0, 9);
            r.scale = (pick < 6) ? 4'($urandom_range(1, 3)) :
                      (pick < 9) ? 4'($urandom_range(4, 8)) :
                      (($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15)));
            r.ox = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 64) - 16) : 11'($urandom);
            r.oy = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 64) - 16) : 11'($urandom);
            pick = $urandom_range(0, 9);
            r.sw = (pick < 7) ? 12'($urandom_range(64, 800)) :
                   (pick < 9) ? 12'd2048 : 12'($urandom);
            pick = $urandom_range(0, 9);
            r.sh = (pick < 7) ? 12'($urandom_range(64, 800)) :
                   (pick < 9) ? 12'd2048 : 12'($urandom);
            apply_regs(r);
            repeat (28) send_pixel(random_pixel());
        end
        drain();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_SEED;
        cfg_wr_data = '0;
        fail_count  = 0;
        bad_writes  = 0;
        steady_flow = 1'b0;
        regs.seed   = '0;
        regs.thr    = '0;
        regs.mode   = REVEAL_NONE;
        regs.scale  = 4'd1;
        regs.ox     = '0;
        regs.oy     = '0;
        regs.sw     = 12'd720;
        regs.sh     = 12'd720;
        build_sine_table();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_block_clipping();
        test_dissolve_sweep();
        test_random_frames();
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pdr_pkg.sv
rtl/pdr_plasma_pipe.sv
rtl/pdr_block_writer.sv
rtl/plasma_dissolve_pixel_reveal_top.sv
rtl/pdr_checker.sv
tb/sv/plasma_dissolve_pixel_reveal_top_tb.sv
